### sv/rtb_pkg.sv
// ----------------------------------------------------------------------------
// rtb_pkg
// Shared types, codes and constants of the retransmission tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package rtb_pkg;

  // default table geometry
  localparam int PEERS_DEF = 8;
  localparam int SLOTS_DEF = 32;

  // configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 16;

  typedef enum logic [CFG_IW-1:0] {
    CFG_RETRY_MIN = 2'd0,
    CFG_RETRY_MAX = 2'd1,
    CFG_MAX_ATT   = 2'd2,
    CFG_MAX_PEND  = 2'd3
  } cfg_idx_t;

  // configuration reset values
  localparam logic [15:0] RETRY_MIN_RST = 16'd100;
  localparam logic [15:0] RETRY_MAX_RST = 16'd3000;
  localparam logic [3:0]  MAX_ATT_RST   = 4'd5;
  localparam logic [5:0]  MAX_PEND_RST  = 6'd32;

  // retry delay: 2*RTT from Q16.4 is a right shift by 3, plus a fixed offset
  localparam int          RTT_SH      = 3;
  localparam logic [17:0] RTT_OFS_MS  = 18'd50;
  localparam logic [2:0]  BACKOFF_MAX = 3'd4;
  localparam logic [3:0]  ATT_SAT     = 4'd15;

  typedef enum logic [2:0] {
    OP_TRACK  = 3'd0,
    OP_ACK    = 3'd1,
    OP_SCAN   = 3'd2,
    OP_RESEND = 3'd3,
    OP_REMOVE = 3'd4,
    OP_DROP   = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    ST_ACCEPTED  = 4'd0,
    ST_FULL      = 4'd1,
    ST_DUPLICATE = 4'd2,
    ST_CONFIRMED = 4'd3,
    ST_UNMATCHED = 4'd4,
    ST_DUE       = 4'd5,
    ST_FAILED    = 4'd6,
    ST_REMOVED   = 4'd7,
    ST_NOT_FOUND = 4'd8,
    ST_ORPHAN    = 4'd9,
    ST_SCAN_DONE = 4'd10
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_WEND,
    S_RDG,
    S_RDW,
    S_DLY0,
    S_DLY1,
    S_DLY2,
    S_WRITE,
    S_EMIT,
    S_RESULT
  } state_t;

  // one table entry as stored in the slot memory
  typedef struct packed {
    logic [31:0] tag;
    logic [15:0] seq;
    logic [3:0]  att;
    logic [31:0] first;
    logic [31:0] retry;
    logic [15:0] handle;
  } ent_t;

  // one result transaction
  typedef struct packed {
    logic [3:0]  status;
    logic [2:0]  peer;
    logic [4:0]  slot;
    logic [31:0] tag;
    logic [15:0] seq;
    logic [3:0]  att;
    logic [31:0] first;
    logic [15:0] handle;
    logic [5:0]  pending;
    logic        last;
  } out_t;

endpackage

`default_nettype wire

### sv/rtb_if.sv
// ----------------------------------------------------------------------------
// rtb_req_if / rtb_res_if
// Valid/ready channels for requests into and results out of the tracker.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtb_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [2:0]  peer;
  logic [31:0] message_tag;
  logic [15:0] sequence_req;
  logic [4:0]  entry_slot;
  logic [31:0] now_ms;
  logic [19:0] rtt_q4;
  logic [15:0] payload_handle;

  modport source (
    output valid, opcode, peer, message_tag, sequence_req, entry_slot,
           now_ms, rtt_q4, payload_handle,
    input  ready
  );
  modport sink (
    input  valid, opcode, peer, message_tag, sequence_req, entry_slot,
           now_ms, rtt_q4, payload_handle,
    output ready
  );
endinterface

interface rtb_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [2:0]  out_peer;
  logic [4:0]  out_slot;
  logic [31:0] out_tag;
  logic [15:0] out_sequence;
  logic [3:0]  attempts;
  logic [31:0] first_sent;
  logic [15:0] out_handle;
  logic [5:0]  pending_now;
  logic        last;

  modport source (
    output valid, status, out_peer, out_slot, out_tag, out_sequence, attempts,
           first_sent, out_handle, pending_now, last,
    input  ready
  );
  modport sink (
    input  valid, status, out_peer, out_slot, out_tag, out_sequence, attempts,
           first_sent, out_handle, pending_now, last,
    output ready
  );
endinterface

`default_nettype wire

### sv/retransmit_tracker_with_backoff_top.sv
// ----------------------------------------------------------------------------
// retransmit_tracker_with_backoff_top
// Per-peer table of unacknowledged messages with exponential retry backoff.
// ----------------------------------------------------------------------------
// One request is handled at a time; ready is high only while the block is
// idle. Every request except a rejected track, a mark resent on an empty or
// out-of-range slot and a drop peer on an empty table walks the addressed
// peer's slots through the registered read port of the slot memory, one slot
// per cycle while no result waits on the output register. A scan walks
// twice (one pass decides, a second pass reports); drop peer walks once and
// reports as it goes. A result waiting on the output register holds the
// block. The retry time is computed by one clamp/shift/add datapath, with
// the clamped base, the shifted and capped delay and the sum registered in
// turn. No clearing pass is needed after reset: slot valid and binding bits
// are flip-flops cleared at once.
// ----------------------------------------------------------------------------
`default_nettype none

module retransmit_tracker_with_backoff_top #(
  parameter int PEERS          = rtb_pkg::PEERS_DEF,
  parameter int SLOTS_PER_PEER = rtb_pkg::SLOTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [rtb_pkg::CFG_IW-1:0] cfg_index,
  input  logic [rtb_pkg::CFG_DW-1:0] cfg_data,
  rtb_req_if.sink                   req,
  rtb_res_if.source                 res
);
  import rtb_pkg::*;

  localparam int NSLOT = PEERS * SLOTS_PER_PEER;
  localparam int AW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
  localparam int SW    = (SLOTS_PER_PEER > 1) ? $clog2(SLOTS_PER_PEER) : 1;
  localparam int PIW   = (PEERS > 1) ? $clog2(PEERS) : 1;
  localparam int CW    = $clog2(SLOTS_PER_PEER + 1);
  localparam int IW    = SW + 1;

  // configuration registers
  logic [15:0] retry_min;
  logic [15:0] retry_max;
  logic [3:0]  max_att;
  logic [5:0]  max_pend;

  // captured request
  logic [2:0]  op_r;
  logic [2:0]  peer_r;
  logic [31:0] tag_r;
  logic [15:0] seq_r;
  logic [4:0]  es_r;
  logic [31:0] now_r;
  logic [19:0] rtt_r;
  logic [15:0] handle_r;

  state_t state, state_next;

  // slot table
  ent_t             mem [NSLOT];
  ent_t             mem_q;
  logic [NSLOT-1:0] valid;
  logic [NSLOT-1:0] bound;
  logic [CW-1:0]    cnt [PEERS];

  // walk sequencer
  logic [IW-1:0]             rd_idx;
  logic                      chk_vld;
  logic [SW-1:0]             chk_idx;
  logic                      hit;
  logic [SW-1:0]             hit_idx;
  logic                      free_found;
  logic [SW-1:0]             free_idx;
  logic [SLOTS_PER_PEER-1:0] mask_bind;
  logic [SLOTS_PER_PEER-1:0] mask_rep;
  logic [SLOTS_PER_PEER-1:0] mask_fail;

  // result staging
  status_t     status_r;
  logic [4:0]  slot_r;
  ent_t        ent_r;
  logic [15:0] dly_base;
  logic [15:0] dly;

  // output register
  logic out_valid;
  out_t out_q;
  out_t res_d;

  // derived addressing
  logic [PIW-1:0]            pidx;
  logic [AW-1:0]             gbase;
  logic [AW-1:0]             chk_g;
  logic [AW-1:0]             es_g;
  logic [AW-1:0]             ra;
  logic                      chk_v;
  logic                      chk_b;
  logic                      es_in;
  logic [CW-1:0]             cnt_cur;
  logic [SLOTS_PER_PEER-1:0] pv;
  logic [SLOTS_PER_PEER-1:0] chk_oh;
  logic                      full;

  // walk control
  logic rd_more;
  logic walk_done;
  logic tag_eq;
  logic seq_eq;
  logic due;
  logic fails;
  logic emit_want;
  logic can_load;
  logic advance;
  logic walk_step;
  logic rd_en;
  logic out_load;

  // retry datapath
  logic [17:0] base_raw;
  logic [15:0] base_cl;
  logic [2:0]  sh;
  logic [19:0] shv;
  logic [15:0] dly_cl;
  logic [32:0] sum;
  logic [31:0] retry_new;
  logic [3:0]  att_inc;

  assign pidx    = PIW'(peer_r);
  assign gbase   = AW'(int'(peer_r) * SLOTS_PER_PEER);
  assign chk_g   = gbase + AW'(chk_idx);
  assign es_g    = gbase + AW'(es_r);
  assign chk_v   = valid[chk_g];
  assign chk_b   = bound[chk_g];
  assign es_in   = int'(es_r) < SLOTS_PER_PEER;
  assign cnt_cur = cnt[pidx];
  assign pv      = valid[gbase +: SLOTS_PER_PEER];
  assign chk_oh  = SLOTS_PER_PEER'(1) << chk_idx;
  assign full    = (7'(cnt_cur) >= 7'(max_pend)) || (int'(cnt_cur) >= SLOTS_PER_PEER);

  assign rd_more   = rd_idx != IW'(SLOTS_PER_PEER);
  assign walk_done = !rd_more && !chk_vld;
  assign tag_eq    = mem_q.tag == tag_r;
  assign seq_eq    = mem_q.seq == seq_r;
  assign due       = now_r >= mem_q.retry;
  assign fails     = mem_q.att >= max_att;
  assign emit_want = (state == S_EMIT) && chk_vld && mask_rep[chk_idx];
  assign can_load  = !out_valid || res.ready;
  assign advance   = !(emit_want && !can_load);
  assign walk_step = ((state == S_WALK) || (state == S_EMIT)) && advance;
  assign rd_en     = (walk_step && rd_more) || (state == S_RDG);
  assign ra        = (state == S_RDG) ? es_g : gbase + AW'(rd_idx[SW-1:0]);
  assign out_load  = (emit_want && can_load) || ((state == S_RESULT) && can_load);

  assign req.ready = (state == S_IDLE);

  // retry delay: clamp base, back off by attempts, cap, then saturating add
  assign base_raw  = (rtt_r != 20'd0) ? 18'(rtt_r >> RTT_SH) + RTT_OFS_MS
                                      : 18'(retry_min);
  assign base_cl   = (base_raw < 18'(retry_min)) ? retry_min :
                     (base_raw > 18'(retry_max)) ? retry_max : base_raw[15:0];
  assign sh        = (ent_r.att <= 4'd1) ? 3'd0 :
                     ((ent_r.att - 4'd1) > 4'(BACKOFF_MAX)) ? BACKOFF_MAX
                                                            : 3'(ent_r.att - 4'd1);
  assign shv       = {4'd0, dly_base} << sh;
  assign dly_cl    = (shv > 20'(retry_max)) ? retry_max : shv[15:0];
  assign sum       = {1'b0, now_r} + 33'(dly);
  assign retry_new = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign att_inc   = (mem_q.att < ATT_SAT) ? mem_q.att + 4'd1 : ATT_SAT;

  // result mux: walk-time report or staged single result
  always_comb begin
    res_d         = '0;
    res_d.peer    = peer_r;
    res_d.pending = 6'(cnt_cur);
    if (state == S_EMIT) begin
      if (op_r == OP_DROP) begin
        res_d.status = ST_ORPHAN;
      end else if (mask_fail[chk_idx]) begin
        res_d.status = ST_FAILED;
      end else begin
        res_d.status = ST_DUE;
      end
      res_d.slot   = 5'(chk_idx);
      res_d.tag    = mem_q.tag;
      res_d.seq    = mem_q.seq;
      res_d.att    = mem_q.att;
      res_d.first  = mem_q.first;
      res_d.handle = mem_q.handle;
      res_d.last   = (op_r == OP_DROP) && ((mask_rep & ~chk_oh) == '0);
    end else begin
      res_d.status = status_r;
      res_d.slot   = slot_r;
      res_d.tag    = ent_r.tag;
      res_d.seq    = ent_r.seq;
      res_d.att    = ent_r.att;
      res_d.first  = ent_r.first;
      res_d.handle = ent_r.handle;
      res_d.last   = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid && int'(req.peer) < PEERS && req.opcode <= OP_DROP) begin
          state_next = S_START;
        end
      end
      S_START: begin
        case (op_r)
          OP_TRACK:  state_next = full ? S_RESULT : S_WALK;
          OP_RESEND: state_next = (!es_in || !valid[es_g]) ? S_RESULT : S_WALK;
          OP_DROP:   state_next = (pv != '0) ? S_EMIT : S_IDLE;
          default:   state_next = S_WALK;
        endcase
      end
      S_WALK: begin
        if (walk_done) begin
          state_next = S_WEND;
        end
      end
      S_WEND: begin
        case (op_r)
          OP_TRACK:  state_next = hit ? S_RESULT : S_DLY0;
          OP_SCAN:   state_next = S_EMIT;
          OP_RESEND: state_next = S_RDG;
          default:   state_next = S_RESULT;
        endcase
      end
      S_RDG:   state_next = S_RDW;
      S_RDW:   state_next = S_DLY0;
      S_DLY0:  state_next = S_DLY1;
      S_DLY1:  state_next = S_DLY2;
      S_DLY2:  state_next = S_WRITE;
      S_WRITE: state_next = S_RESULT;
      S_EMIT: begin
        if (walk_done) begin
          state_next = (op_r == OP_SCAN) ? S_RESULT : S_IDLE;
        end
      end
      S_RESULT: begin
        if (can_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state, configuration, table flags and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      retry_min <= RETRY_MIN_RST;
      retry_max <= RETRY_MAX_RST;
      max_att   <= MAX_ATT_RST;
      max_pend  <= MAX_PEND_RST;
      valid     <= '0;
      bound     <= '0;
      for (int p = 0; p < PEERS; p++) begin
        cnt[p] <= '0;
      end
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_RETRY_MIN: retry_min <= cfg_data;
          CFG_RETRY_MAX: retry_max <= cfg_data;
          CFG_MAX_ATT:   max_att   <= cfg_data[3:0];
          CFG_MAX_PEND:  max_pend  <= cfg_data[5:0];
          default: ;
        endcase
      end

      // drop peer empties the table up front
      if (state == S_START && op_r == OP_DROP) begin
        valid[gbase +: SLOTS_PER_PEER] <= '0;
        bound[gbase +: SLOTS_PER_PEER] <= '0;
        cnt[pidx] <= '0;
      end

      // scan removes exhausted entries as it finds them
      if (state == S_WALK && op_r == OP_SCAN && chk_vld && chk_v && due && fails) begin
        valid[chk_g] <= 1'b0;
        bound[chk_g] <= 1'b0;
        cnt[pidx]    <= cnt_cur - CW'(1);
      end

      // ack and remove delete the matched entry
      if (state == S_WEND && (op_r == OP_ACK || op_r == OP_REMOVE) && hit) begin
        valid[gbase + AW'(hit_idx)] <= 1'b0;
        bound[gbase + AW'(hit_idx)] <= 1'b0;
        cnt[pidx] <= cnt_cur - CW'(1);
      end

      // newest binding wins: clear older holders of the sequence, then bind
      if (state == S_WRITE) begin
        for (int j = 0; j < SLOTS_PER_PEER; j++) begin
          if (mask_bind[j]) begin
            bound[gbase + AW'(j)] <= 1'b0;
          end
        end
        valid[gbase + AW'(hit_idx)] <= 1'b1;
        bound[gbase + AW'(hit_idx)] <= 1'b1;
        if (op_r == OP_TRACK) begin
          cnt[pidx] <= cnt_cur + CW'(1);
        end
      end
    end
  end

  // slot memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      mem[gbase + AW'(hit_idx)] <= ent_r;
    end
    if (rd_en) begin
      mem_q <= mem[ra];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_q <= res_d;
    end
  end

  // request capture, walk sequencer and result staging
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      op_r     <= req.opcode;
      peer_r   <= req.peer;
      tag_r    <= req.message_tag;
      seq_r    <= req.sequence_req;
      es_r     <= req.entry_slot;
      now_r    <= req.now_ms;
      rtt_r    <= req.rtt_q4;
      handle_r <= req.payload_handle;
    end

    // shared walk step
    if (walk_step) begin
      chk_vld <= rd_more;
      chk_idx <= rd_idx[SW-1:0];
      if (rd_more) begin
        rd_idx <= rd_idx + IW'(1);
      end
    end

    case (state)
      S_START: begin
        rd_idx     <= '0;
        chk_vld    <= 1'b0;
        hit        <= 1'b0;
        free_found <= 1'b0;
        mask_bind  <= '0;
        mask_fail  <= '0;
        mask_rep   <= (op_r == OP_DROP) ? pv : '0;
        slot_r     <= '0;
        ent_r      <= '0;
        if (op_r == OP_TRACK) begin
          status_r     <= ST_FULL;
          ent_r.tag    <= tag_r;
          ent_r.seq    <= seq_r;
          ent_r.handle <= handle_r;
        end else begin
          status_r  <= ST_NOT_FOUND;
          slot_r    <= es_r;
          ent_r.seq <= seq_r;
        end
      end

      S_WALK: begin
        if (chk_vld) begin
          case (op_r)
            OP_TRACK: begin
              if (chk_v && tag_eq && !hit) begin
                hit     <= 1'b1;
                hit_idx <= chk_idx;
                slot_r  <= 5'(chk_idx);
                ent_r   <= mem_q;
              end
              if (!chk_v && !free_found) begin
                free_found <= 1'b1;
                free_idx   <= chk_idx;
              end
              if (chk_v && chk_b && seq_eq) begin
                mask_bind[chk_idx] <= 1'b1;
              end
            end
            OP_ACK: begin
              if (chk_v && chk_b && seq_eq && !hit) begin
                hit     <= 1'b1;
                hit_idx <= chk_idx;
                slot_r  <= 5'(chk_idx);
                ent_r   <= mem_q;
              end
            end
            OP_REMOVE: begin
              if (chk_v && tag_eq && !hit) begin
                hit     <= 1'b1;
                hit_idx <= chk_idx;
                slot_r  <= 5'(chk_idx);
                ent_r   <= mem_q;
              end
            end
            OP_RESEND: begin
              if (chk_v && chk_b && seq_eq) begin
                mask_bind[chk_idx] <= 1'b1;
              end
            end
            OP_SCAN: begin
              if (chk_v && due) begin
                mask_rep[chk_idx]  <= 1'b1;
                mask_fail[chk_idx] <= fails;
              end
            end
            default: ;
          endcase
        end
      end

      S_WEND: begin
        rd_idx  <= '0;
        chk_vld <= 1'b0;
        case (op_r)
          OP_TRACK: begin
            if (hit) begin
              status_r <= ST_DUPLICATE;
            end else begin
              status_r     <= ST_ACCEPTED;
              hit_idx      <= free_idx;
              slot_r       <= 5'(free_idx);
              ent_r.tag    <= tag_r;
              ent_r.seq    <= seq_r;
              ent_r.att    <= 4'd1;
              ent_r.first  <= now_r;
              ent_r.retry  <= '0;
              ent_r.handle <= handle_r;
            end
          end
          OP_ACK: begin
            if (hit) begin
              status_r <= ST_CONFIRMED;
            end else begin
              status_r  <= ST_UNMATCHED;
              slot_r    <= '0;
              ent_r     <= '0;
              ent_r.seq <= seq_r;
            end
          end
          OP_REMOVE: begin
            if (hit) begin
              status_r <= ST_REMOVED;
            end else begin
              status_r  <= ST_NOT_FOUND;
              slot_r    <= '0;
              ent_r     <= '0;
              ent_r.tag <= tag_r;
            end
          end
          default: ;
        endcase
      end

      // mark resent: bring in the entry, rebind and count the attempt
      S_RDW: begin
        status_r  <= ST_ACCEPTED;
        hit_idx   <= SW'(es_r);
        slot_r    <= es_r;
        ent_r     <= mem_q;
        ent_r.seq <= seq_r;
        ent_r.att <= att_inc;
      end

      S_DLY0: dly_base <= base_cl;
      S_DLY1: dly <= dly_cl;
      S_DLY2: ent_r.retry <= retry_new;

      S_EMIT: begin
        if (emit_want && can_load) begin
          mask_rep[chk_idx] <= 1'b0;
        end
        if (walk_done) begin
          status_r <= ST_SCAN_DONE;
          slot_r   <= '0;
          ent_r    <= '0;
        end
      end

      default: ;
    endcase
  end

  assign res.valid        = out_valid;
  assign res.status       = out_q.status;
  assign res.out_peer     = out_q.peer;
  assign res.out_slot     = out_q.slot;
  assign res.out_tag      = out_q.tag;
  assign res.out_sequence = out_q.seq;
  assign res.attempts     = out_q.att;
  assign res.first_sent   = out_q.first;
  assign res.out_handle   = out_q.handle;
  assign res.pending_now  = out_q.pending;
  assign res.last         = out_q.last;

endmodule

`default_nettype wire

### sv/rtb_checker.sv
// ----------------------------------------------------------------------------
// rtb_checker
// Port-level checks of the retransmission tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rtb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [2:0]  in_opcode,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  out_status,
  input wire logic [4:0]  out_slot,
  input wire logic [31:0] out_tag,
  input wire logic [5:0]  out_pending,
  input wire logic        out_last
);
  import rtb_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_tag))
    else $error("result changed while stalled");

  // one request at a time: busy right after a known-opcode transaction
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_opcode <= OP_DROP) |=> !in_ready)
    else $error("request taken while busy");

  // scan done always closes the scan
  a_scan_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_SCAN_DONE |-> out_last && out_slot == 5'd0)
    else $error("scan done not final");

  // orphans are reported from an already emptied table
  a_orphan: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_ORPHAN |-> out_pending == 6'd0)
    else $error("orphan with entries pending");

endmodule

bind retransmit_tracker_with_backoff_top rtb_checker u_rtb_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .in_opcode   (req.opcode),
  .out_valid   (res.valid),
  .out_ready   (res.ready),
  .out_status  (res.status),
  .out_slot    (res.out_slot),
  .out_tag     (res.out_tag),
  .out_pending (res.pending_now),
  .out_last    (res.last)
);

`default_nettype wire

### tb/retransmit_tracker_with_backoff_top_tb.sv
// ----------------------------------------------------------------------------
// retransmit_tracker_with_backoff_top_tb
// Drives requests for the retransmission tracker, predicts every result with a
// behavioral copy of the per-peer tables, and compares result transactions in
// order, field by field. Random gaps and stalls fall on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module retransmit_tracker_with_backoff_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtb_pkg::*;

  localparam int NPEER  = PEERS_DEF;
  localparam int NSLOTS = SLOTS_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  // one request
  typedef struct {
    op_t         op;
    logic [2:0]  peer;
    logic [31:0] tag;
    logic [15:0] seq;
    logic [4:0]  slot;
    logic [31:0] now;
    logic [19:0] rtt;
    logic [15:0] handle;
  } req_t;

  // behavioral tracker and expected-result store
  class tracker_board;
    bit          valid [NPEER*NSLOTS];
    bit          bound [NPEER*NSLOTS];
    logic [31:0] tag   [NPEER*NSLOTS];
    logic [15:0] seq   [NPEER*NSLOTS];
    logic [3:0]  att   [NPEER*NSLOTS];
    logic [31:0] first [NPEER*NSLOTS];
    logic [31:0] retry [NPEER*NSLOTS];
    logic [15:0] hndl  [NPEER*NSLOTS];
    int unsigned rmin, rmax, max_att, max_pend;
    out_t        pending_results[$];
    int          errors;

    function void reset_state();
      foreach (valid[i]) begin
        valid[i] = 0;
        bound[i] = 0;
      end
      rmin = RETRY_MIN_RST;
      rmax = RETRY_MAX_RST;
      max_att = MAX_ATT_RST;
      max_pend = MAX_PEND_RST;
      pending_results.delete();
      errors = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] v);
      case (idx)
        CFG_RETRY_MIN: rmin = v;
        CFG_RETRY_MAX: rmax = v;
        CFG_MAX_ATT:   max_att = v[3:0];
        default:       max_pend = v[5:0];
      endcase
    endfunction

    function logic [31:0] retry_time(logic [31:0] now, logic [19:0] rtt, int unsigned a);
      longint unsigned b, sh, v, t;
      b = (rtt != 0) ? (rtt >> 3) + 50 : rmin;
      sh = (a <= 1) ? 0 : ((a - 1 > 4) ? 4 : a - 1);
      if (b < rmin) b = rmin;
      else if (b > rmax) b = rmax;
      v = b << sh;
      if (v > rmax) v = rmax;
      t = now + v;
      return (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
    endfunction

    function out_t plain(status_t st, logic [2:0] p, logic [4:0] s, logic [31:0] t,
                         logic [15:0] q, logic [15:0] h);
      out_t o;
      o = '0;
      o.status = st; o.peer = p; o.slot = s; o.tag = t; o.seq = q; o.handle = h;
      return o;
    endfunction

    function out_t entry(status_t st, logic [2:0] p, int s);
      out_t o;
      int g;
      g = p * NSLOTS + s;
      o = plain(st, p, s[4:0], tag[g], seq[g], hndl[g]);
      o.att = att[g];
      o.first = first[g];
      return o;
    endfunction

    function void bind_sequence(int b, int g, logic [15:0] q);
      for (int i = 0; i < NSLOTS; i++)
        if (valid[b+i] && bound[b+i] && seq[b+i] == q) bound[b+i] = 0;
      seq[g] = q;
      bound[g] = 1;
    endfunction

    function int peer_count(int b);
      int c;
      c = 0;
      for (int i = 0; i < NSLOTS; i++) c += valid[b+i];
      return c;
    endfunction

    // note an accepted request and queue what it should produce
    function void note_request(req_t r);
      out_t res[$];
      int b, hit, g, c;
      if (r.peer >= NPEER || r.op > OP_DROP) return;
      b = r.peer * NSLOTS;
      hit = -1;
      case (r.op)
        OP_TRACK: begin
          c = peer_count(b);
          if (c >= max_pend || c >= NSLOTS) begin
            res.push_back(plain(ST_FULL, r.peer, 0, r.tag, r.seq, r.handle));
          end else begin
            for (int i = 0; i < NSLOTS; i++)
              if (hit < 0 && valid[b+i] && tag[b+i] == r.tag) hit = i;
            if (hit >= 0) res.push_back(entry(ST_DUPLICATE, r.peer, hit));
            else begin
              for (int i = 0; i < NSLOTS; i++)
                if (hit < 0 && !valid[b+i]) hit = i;
              g = b + hit;
              valid[g] = 1; tag[g] = r.tag; att[g] = 1; first[g] = r.now;
              retry[g] = retry_time(r.now, r.rtt, 1);
              hndl[g] = r.handle;
              bind_sequence(b, g, r.seq);
              res.push_back(entry(ST_ACCEPTED, r.peer, hit));
            end
          end
        end
        OP_ACK: begin
          for (int i = 0; i < NSLOTS; i++)
            if (hit < 0 && valid[b+i] && bound[b+i] && seq[b+i] == r.seq) hit = i;
          if (hit >= 0) begin
            res.push_back(entry(ST_CONFIRMED, r.peer, hit));
            valid[b+hit] = 0; bound[b+hit] = 0;
          end else res.push_back(plain(ST_UNMATCHED, r.peer, 0, 0, r.seq, 0));
        end
        OP_SCAN: begin
          for (int i = 0; i < NSLOTS; i++) begin
            g = b + i;
            if (valid[g] && r.now >= retry[g]) begin
              if (att[g] >= max_att) begin
                res.push_back(entry(ST_FAILED, r.peer, i));
                valid[g] = 0; bound[g] = 0;
              end else res.push_back(entry(ST_DUE, r.peer, i));
            end
          end
          res.push_back(plain(ST_SCAN_DONE, r.peer, 0, 0, 0, 0));
        end
        OP_RESEND: begin
          g = b + r.slot;
          if (!valid[g]) res.push_back(plain(ST_NOT_FOUND, r.peer, r.slot, 0, r.seq, 0));
          else begin
            bound[g] = 0;
            bind_sequence(b, g, r.seq);
            if (att[g] < ATT_SAT) att[g]++;
            retry[g] = retry_time(r.now, r.rtt, att[g]);
            res.push_back(entry(ST_ACCEPTED, r.peer, r.slot));
          end
        end
        OP_REMOVE: begin
          for (int i = 0; i < NSLOTS; i++)
            if (hit < 0 && valid[b+i] && tag[b+i] == r.tag) hit = i;
          if (hit >= 0) begin
            res.push_back(entry(ST_REMOVED, r.peer, hit));
            valid[b+hit] = 0; bound[b+hit] = 0;
          end else res.push_back(plain(ST_NOT_FOUND, r.peer, 0, r.tag, 0, 0));
        end
        default: begin
          for (int i = 0; i < NSLOTS; i++)
            if (valid[b+i]) begin
              res.push_back(entry(ST_ORPHAN, r.peer, i));
              valid[b+i] = 0; bound[b+i] = 0;
            end
        end
      endcase
      c = peer_count(b);
      foreach (res[k]) begin
        res[k].pending = c[5:0];
        res[k].last = (k == res.size() - 1);
        pending_results.push_back(res[k]);
      end
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    // compare one result transaction against the oldest expectation
    task check_result(out_t got);
      out_t w;
      if (pending_results.size() == 0) begin
        report("unexpected result, status", 32'(got.status), 32'd0);
        return;
      end
      w = pending_results.pop_front();
      if (got.status  !== w.status)  report("status", got.status, w.status);
      if (got.peer    !== w.peer)    report("out_peer", got.peer, w.peer);
      if (got.slot    !== w.slot)    report("out_slot", got.slot, w.slot);
      if (got.tag     !== w.tag)     report("out_tag", got.tag, w.tag);
      if (got.seq     !== w.seq)     report("out_sequence", got.seq, w.seq);
      if (got.att     !== w.att)     report("attempts", got.att, w.att);
      if (got.first   !== w.first)   report("first_sent", got.first, w.first);
      if (got.handle  !== w.handle)  report("out_handle", got.handle, w.handle);
      if (got.pending !== w.pending) report("pending_now", got.pending, w.pending);
      if (got.last    !== w.last)    report("last", got.last, w.last);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  rtb_req_if req_ch();
  rtb_res_if res_ch();

  retransmit_tracker_with_backoff_top u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req_ch.sink), .res(res_ch.source)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  tracker_board board;
  logic [31:0] clock_ms = 0;
  logic [31:0] tags_used[8][$];
  int idle_cycles = 0;
  int hold_off = 0;
  bit sink_random = 1;

  initial begin
    req_ch.valid = 0;
    req_ch.opcode = '0; req_ch.peer = '0; req_ch.message_tag = '0;
    req_ch.sequence_req = '0; req_ch.entry_slot = '0; req_ch.now_ms = '0;
    req_ch.rtt_q4 = '0; req_ch.payload_handle = '0;
    res_ch.ready = 0;
  end

  // result side: random stalls, long hold-off on request, compare on accept
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      board.check_result({res_ch.status, res_ch.out_peer, res_ch.out_slot, res_ch.out_tag,
                          res_ch.out_sequence, res_ch.attempts, res_ch.first_sent,
                          res_ch.out_handle, res_ch.pending_now, res_ch.last});
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      res_ch.ready <= 0;
    end else if (!sink_random) res_ch.ready <= 1;
    else if ($urandom_range(0, 49) == 0) begin
      hold_off <= $urandom_range(10, 40);
      res_ch.ready <= 0;
    end else res_ch.ready <= ($urandom_range(0, 9) < 7) ? 1'b1 : 1'b0;
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("retransmit_tracker_with_backoff_top_tb NOT OK");
      $finish;
    end
  end

  // valid stays high after a transaction until a gap or a drain lowers it
  task automatic send(req_t r);
    int gap;
    gap = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(5, 40);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      req_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1;
    req_ch.opcode <= r.op; req_ch.peer <= r.peer; req_ch.message_tag <= r.tag;
    req_ch.sequence_req <= r.seq; req_ch.entry_slot <= r.slot; req_ch.now_ms <= r.now;
    req_ch.rtt_q4 <= r.rtt; req_ch.payload_handle <= r.handle;
    do @(posedge clk); while (!req_ch.ready);
    board.note_request(r);
  endtask

  task automatic drain();
    req_ch.valid <= 0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    board.set_reg(idx, v);
  endtask

  function automatic req_t mk(op_t op, logic [2:0] p);
    req_t r;
    r.op = op; r.peer = p;
    r.tag = $urandom(); r.seq = 16'($urandom()); r.slot = 5'($urandom_range(0, 31));
    r.now = clock_ms;
    r.rtt = ($urandom_range(0, 3) == 0) ? 20'd0 : 20'($urandom_range(0, 40000));
    if ($urandom_range(0, 15) == 0) r.rtt = 20'($urandom());
    r.handle = 16'($urandom());
    return r;
  endfunction

  // mostly well-formed traffic: tracks, acks, scans, mark resents, removes of known tags, drops
  task automatic random_item(logic [2:0] pmax);
    req_t r;
    int k;
    logic [2:0] p;
    p = 3'($urandom_range(0, pmax));
    k = $urandom_range(0, 99);
    clock_ms = clock_ms + $urandom_range(0, 600);
    if ($urandom_range(0, 60) == 0) clock_ms = clock_ms + $urandom();
    if (k < 35) begin
      r = mk(OP_TRACK, p);
      if (tags_used[p].size() != 0 && $urandom_range(0, 5) == 0)
        r.tag = tags_used[p][$urandom_range(0, tags_used[p].size() - 1)];
      else r.seq = 16'($urandom_range(0, 40));
      tags_used[p].push_back(r.tag);
    end else if (k < 50) begin
      r = mk(OP_ACK, p); r.seq = 16'($urandom_range(0, 45));
    end else if (k < 68) begin
      r = mk(OP_SCAN, p);
    end else if (k < 82) begin
      r = mk(OP_RESEND, p); r.slot = 5'($urandom_range(0, 7));
      r.seq = 16'($urandom_range(0, 40));
    end else if (k < 92) begin
      r = mk(OP_REMOVE, p);
      if (tags_used[p].size() != 0 && k < 89)
        r.tag = tags_used[p][$urandom_range(0, tags_used[p].size() - 1)];
    end else if (k < 96) begin
      r = mk(OP_DROP, p);
    end else begin
      r = mk(op_t'($urandom_range(6, 7)), p);
    end
    send(r);
  endtask

  initial begin
    req_t r;
    board = new();
    board.reset_state();
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: every operation, extremes and the corner cases
    r = mk(OP_TRACK, 0); r.tag = 32'hFFFF_FFFF; r.seq = 16'hFFFF; r.handle = 16'hFFFF;
    r.now = 32'hFFFF_FFF0; r.rtt = 20'hFFFFF; send(r);          // retry saturates
    r = mk(OP_TRACK, 0); r.tag = 0; r.seq = 16'hFFFF; r.handle = 0; r.rtt = 0; send(r);
    r = mk(OP_TRACK, 0); r.tag = 0; send(r);                    // duplicate tag
    r = mk(OP_ACK, 0); r.seq = 16'hFFFF; send(r);               // newest binding wins
    r = mk(OP_ACK, 0); r.seq = 16'hFFFF; send(r);               // now unmatched
    r = mk(OP_RESEND, 7); r.slot = 31; send(r);                 // empty slot
    r = mk(OP_TRACK, 7); r.tag = 5; r.seq = 1; send(r);
    for (int i = 0; i < 16; i++) begin                          // attempts saturate
      r = mk(OP_RESEND, 7); r.slot = 0; r.seq = 2; send(r);
    end
    r = mk(OP_SCAN, 7); r.now = 32'hFFFF_FFFF; send(r);         // failed entry
    r = mk(OP_REMOVE, 7); r.tag = 5; send(r);                   // remove miss
    r = mk(OP_DROP, 0); send(r);
    r = mk(OP_DROP, 3); send(r);                                // empty: no result
    r = mk(OP_SCAN, 1); r.now = 0; send(r);
    drain();

    // phases of random traffic across register settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_MAX_PEND, 16'd2); write_reg(CFG_MAX_ATT, 16'd1);
          write_reg(CFG_RETRY_MIN, 16'd0); write_reg(CFG_RETRY_MAX, 16'd1);
        end
        1: begin
          write_reg(CFG_MAX_PEND, 16'd32); write_reg(CFG_MAX_ATT, 16'd15);
          write_reg(CFG_RETRY_MIN, 16'hFFFF); write_reg(CFG_RETRY_MAX, 16'hFFFF);
        end
        2: begin
          write_reg(CFG_MAX_PEND, 16'd63); write_reg(CFG_MAX_ATT, 16'd3);
          write_reg(CFG_RETRY_MIN, 16'd300); write_reg(CFG_RETRY_MAX, 16'd200);
        end
        3: begin
          write_reg(CFG_MAX_PEND, 16'd5); write_reg(CFG_MAX_ATT, 16'd2);
          write_reg(CFG_RETRY_MIN, 16'd40); write_reg(CFG_RETRY_MAX, 16'd2500);
        end
        default: begin
          write_reg(CFG_MAX_PEND, 16'd32); write_reg(CFG_MAX_ATT, 16'd5);
          write_reg(CFG_RETRY_MIN, 16'd100); write_reg(CFG_RETRY_MAX, 16'd3000);
        end
      endcase
      cfg_we <= 0;
      if (ph == 1) begin
        // fill one peer completely, with the receiver held off meanwhile
        hold_off = 400;
        for (int i = 0; i < 34; i++) begin
          r = mk(OP_TRACK, 6); send(r);
        end
        r = mk(OP_DROP, 6); send(r);
      end
      if (ph == 3) sink_random = 0;
      for (int i = 0; i < 30; i++) random_item(ph == 2 ? 3'd7 : 3'd1);
      sink_random = 1;
      drain();                                                  // sender pauses here
    end

    if (board.errors == 0 && board.pending_results.size() == 0)
      $display("retransmit_tracker_with_backoff_top_tb OK");
    else
      $display("retransmit_tracker_with_backoff_top_tb NOT OK");
    $finish;
  end
endmodule

`default_nettype wire
